[sv/ramdac_palette_lookup_assert.svh]
// Assertion macros used by the command queue of the palette lookup RTL.
`ifndef RAMDAC_PALETTE_LOOKUP_ASSERT_SVH
`define RAMDAC_PALETTE_LOOKUP_ASSERT_SVH

// Check an expression at every clock edge outside reset.
`define RPL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a consequence on the next clock edge.
`define RPL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/rpl_pkg.sv]
// Types and constants of the palette lookup block.
package rpl_pkg;

  // Register offsets of a write access.
  localparam logic [2:0] OFS_ADDRESS = 3'd0;
  localparam logic [2:0] OFS_COLOR   = 3'd1;
  localparam logic [2:0] OFS_PIXMASK = 3'd2;
  localparam logic [2:0] OFS_COMMAND = 3'd6;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  // Color byte that the next offset-1 write supplies.
  localparam logic [1:0] CC_RED   = 2'd0;
  localparam logic [1:0] CC_GREEN = 2'd1;
  localparam logic [1:0] CC_BLUE  = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [2:0]  reg_offset;
    logic [7:0]  write_data;
    logic [15:0] pixel_word;
  } req_t;

  typedef struct packed {
    logic [23:0] first_color;
    logic [23:0] second_color;
    logic        unhandled_write;
  } rsp_t;

  // Work handed from the front to the back; each one yields one response.
  typedef enum logic [1:0] {
    CMD_STATUS,
    CMD_WRITE,
    CMD_LOOKUP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        unhandled;
    logic [7:0]  addr;
    logic [23:0] color;
    logic [7:0]  idx0;
    logic [7:0]  idx1;
  } cmd_t;

  // Push side of the command queue.
  typedef struct packed {
    logic push;
    cmd_t cmd;
  } qpush_t;

endpackage

[sv/rpl_front.sv]
// Front end: accepts requests, runs the register file and emits commands.
module rpl_front
  import rpl_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   req_valid,
  output logic   req_ready,
  input  req_t   req,
  input  logic   q_ready,
  output qpush_t q_in
);

  logic [7:0] palette_address, palette_address_next;
  logic [1:0] component_count, component_count_next;
  logic [7:0] staged_red, staged_red_next;
  logic [7:0] staged_green, staged_green_next;
  logic [7:0] pixel_mask, pixel_mask_next;
  logic [7:0] command_byte, command_byte_next;
  logic       accept;
  cmd_t       cmd;

  assign req_ready = q_ready;
  assign accept    = req_valid && q_ready;
  assign q_in.push = accept;
  assign q_in.cmd  = cmd;

  always_comb begin
    palette_address_next = palette_address;
    component_count_next = component_count;
    staged_red_next      = staged_red;
    staged_green_next    = staged_green;
    pixel_mask_next      = pixel_mask;
    command_byte_next    = command_byte;
    cmd                  = '0;
    cmd.kind             = CMD_STATUS;
    if (req.mode == MODE_PIXEL) begin
      cmd.kind = CMD_LOOKUP;
      cmd.idx0 = req.pixel_word[7:0];
      cmd.idx1 = req.pixel_word[15:8];
    end else begin
      case (req.reg_offset)
        OFS_ADDRESS: begin
          palette_address_next = req.write_data;
          component_count_next = CC_RED;
        end
        OFS_COLOR: begin
          case (component_count)
            CC_RED: begin
              staged_red_next      = req.write_data;
              component_count_next = CC_GREEN;
            end
            CC_GREEN: begin
              staged_green_next    = req.write_data;
              component_count_next = CC_BLUE;
            end
            default: begin
              // Blue byte: commit the entry and advance the address.
              cmd.kind             = CMD_WRITE;
              cmd.addr             = palette_address;
              cmd.color            = {staged_red, staged_green, req.write_data};
              component_count_next = CC_RED;
              palette_address_next = palette_address + 8'd1;
            end
          endcase
        end
        OFS_PIXMASK: pixel_mask_next   = req.write_data;
        OFS_COMMAND: command_byte_next = req.write_data;
        default:     cmd.unhandled     = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_address <= '0;
      component_count <= CC_RED;
      staged_red      <= '0;
      staged_green    <= '0;
      pixel_mask      <= '0;
      command_byte    <= '0;
    end else if (accept) begin
      palette_address <= palette_address_next;
      component_count <= component_count_next;
      staged_red      <= staged_red_next;
      staged_green    <= staged_green_next;
      pixel_mask      <= pixel_mask_next;
      command_byte    <= command_byte_next;
    end
  end

endmodule

[sv/rpl_queue.sv]
// Small command queue between front and back.
module rpl_queue
  import rpl_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  qpush_t q_in,
  output logic   q_ready,
  output logic   q_valid,
  input  logic   q_pop,
  output cmd_t   q_cmd
);

`include "ramdac_palette_lookup_assert.svh"

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign q_ready = (count != CW'(DEPTH));
  assign q_valid = (count != '0);
  assign q_cmd   = slots[rd_ptr];
  assign do_push = q_in.push && q_ready;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= q_in.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (!do_push && do_pop) begin
        count <= count - CW'(1);
      end
    end
  end

  `RPL_ASSERT(a_count_bound, count <= CW'(DEPTH), "queue count beyond depth")
  `RPL_ASSERT(a_no_push_full, !(q_in.push && !q_ready), "front pushed into a full queue")
  `RPL_ASSERT(a_no_pop_empty, !(q_pop && !q_valid), "back popped an empty queue")
  `RPL_ASSERT_NEXT(a_push_empty, do_push && !do_pop && count == '0, count == CW'(1),
                   "push into empty queue lost")

endmodule

[sv/rpl_back.sv]
// Back end: palette memory, write commit and two-port lookup.
module rpl_back
  import rpl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_pop,
  input  cmd_t q_cmd,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic [23:0] palette [256];
  logic [255:0] written;
  logic [23:0] rd0, rd1;
  logic        hit0, hit1;
  logic        is_lookup;
  logic        unhandled;

  // Advance when the output register is free or being drained.
  assign q_pop = q_valid && (!rsp_valid || rsp_ready);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (q_cmd.kind == CMD_WRITE) begin
        palette[q_cmd.addr] <= q_cmd.color;
      end
      rd0 <= palette[q_cmd.idx0];
      rd1 <= palette[q_cmd.idx1];
    end
  end

  // Entries never written read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (q_pop && q_cmd.kind == CMD_WRITE) begin
      written[q_cmd.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      hit0      <= written[q_cmd.idx0];
      hit1      <= written[q_cmd.idx1];
      is_lookup <= (q_cmd.kind == CMD_LOOKUP);
      unhandled <= q_cmd.unhandled;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (q_pop) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  assign rsp.first_color     = (is_lookup && hit0) ? rd0 : '0;
  assign rsp.second_color    = (is_lookup && hit1) ? rd1 : '0;
  assign rsp.unhandled_write = unhandled;

endmodule

[sv/ramdac_palette_lookup.sv]
// Top level of the RAMDAC palette lookup block.
//
//   channel   valid      ready      payload   carries
//   request   req_valid  req_ready  req       register write or pixel word
//   response  rsp_valid  rsp_ready  rsp       two colors and unhandled flag
//
// One request per cycle sustained while responses are taken; a response
// passes through the command queue, then the registered palette read, after
// its request is accepted. Every request yields exactly one response, in order.
// Reset (rst, synchronous) clears the register file, queue, output valid and
// the per-entry written bits, so the whole palette reads as zero at once.
// A stalled response holds in the output register; the queue absorbs up to
// QUEUE_DEPTH requests before req_ready drops.
module ramdac_palette_lookup
  import rpl_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  qpush_t q_in;
  logic   q_ready;
  logic   q_valid;
  logic   q_pop;
  cmd_t   q_cmd;

  // Front: decode the request, update address/counter/staging, emit a command.
  rpl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .q_ready   (q_ready),
    .q_in      (q_in)
  );

  // Queue: decouple decode from palette access.
  rpl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_in    (q_in),
    .q_ready (q_ready),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_cmd   (q_cmd)
  );

  // Back: commit palette writes and look up both pixels in order.
  rpl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cmd     (q_cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the RAMDAC palette lookup block.
module tb_top;
  import rpl_pkg::*;

  // Offsets that the block does not decode; any write there raises the flag.
  localparam logic [2:0] OFS_SPARE3 = 3'd3;
  localparam logic [2:0] OFS_SPARE4 = 3'd4;
  localparam logic [2:0] OFS_SPARE5 = 3'd5;
  localparam logic [2:0] OFS_SPARE7 = 3'd7;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_OFF_CYCLES = 200;

  // One row of the directed plan: a request and, where it is obvious, its response.
  typedef struct packed {
    req_t rq;
    logic pinned;
    rsp_t rs;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // Typed-in response that travels with the request being offered.
  logic pin_valid = 1'b0;
  rsp_t pin_rsp = '0;

  // Shadow of the block's state, advanced at every accepted request.
  logic [23:0] shadow_palette [256];
  logic [7:0]  shadow_addr;
  logic [1:0]  shadow_count;
  logic [7:0]  shadow_red;
  logic [7:0]  shadow_green;
  logic [7:0]  shadow_mask;
  logic [7:0]  shadow_command;

  rsp_t expected_colors [$];
  step_t directed_plan [$];

  int send_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_cycles = 0;
  int issued = 0;
  int errors = 0;
  int cycles = 0;
  int n_lookups = 0;
  int n_color_bytes = 0;
  int n_unhandled = 0;
  int n_responses = 0;

  ramdac_palette_lookup u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #10 clk = ~clk;

  // Apply one request to the shadow state and return the response it yields.
  function automatic rsp_t apply_request(req_t r);
    rsp_t res;
    res = '0;
    if (r.mode == MODE_PIXEL) begin
      res.first_color  = shadow_palette[r.pixel_word[7:0]];
      res.second_color = shadow_palette[r.pixel_word[15:8]];
    end else begin
      case (r.reg_offset)
        OFS_ADDRESS: begin
          shadow_addr  = r.write_data;
          shadow_count = CC_RED;
        end
        OFS_COLOR: begin
          // Stage red, then green; the blue byte commits the entry and
          // advances the address, wrapping past 255.
          if (shadow_count == CC_RED) begin
            shadow_red   = r.write_data;
            shadow_count = CC_GREEN;
          end else if (shadow_count == CC_GREEN) begin
            shadow_green = r.write_data;
            shadow_count = CC_BLUE;
          end else begin
            shadow_palette[shadow_addr] = {shadow_red, shadow_green, r.write_data};
            shadow_count = CC_RED;
            shadow_addr  = shadow_addr + 8'd1;
          end
        end
        OFS_PIXMASK: shadow_mask = r.write_data;
        OFS_COMMAND: shadow_command = r.write_data;
        default: res.unhandled_write = 1'b1;
      endcase
    end
    return res;
  endfunction

  function automatic step_t plan_step(logic md, logic [2:0] ofs, logic [7:0] data,
                                      logic [15:0] word, logic pin, logic [23:0] c0,
                                      logic [23:0] c1, logic flag);
    step_t s;
    s.rq.mode = md;
    s.rq.reg_offset = ofs;
    s.rq.write_data = data;
    s.rq.pixel_word = word;
    s.pinned = pin;
    s.rs.first_color = c0;
    s.rs.second_color = c1;
    s.rs.unhandled_write = flag;
    return s;
  endfunction

  // Fill the fields a request does not use with noise as well.
  function automatic req_t rand_request(logic md, logic [2:0] ofs);
    req_t r;
    r.mode = md;
    r.reg_offset = ofs;
    r.write_data = 8'($urandom_range(255));
    r.pixel_word = 16'($urandom_range(65535));
    return r;
  endfunction

  // Offer one request from a falling edge and hold it until accepted.
  // Before offering, idle repeatedly, each time with the sender's idle odds.
  // Returns at the falling edge after acceptance, valid still high.
  task automatic send_request(req_t r, logic pin, rsp_t pr);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req = r;
    pin_valid = pin;
    pin_rsp = pr;
    req_valid = 1'b1;
    do @(posedge clk); while (!req_ready);
    issued++;
    @(negedge clk);
  endtask

  // Mostly palette loads and lookups, with stray color bytes and noise writes.
  task automatic drive_random_traffic(int n_items);
    int target;
    int pick;
    int n_bytes;
    target = issued + n_items;
    while (issued < target) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        send_request(rand_request(MODE_PIXEL, 3'($urandom_range(7))), 1'b0, '0);
      end else if (pick < 65) begin
        n_bytes = 3 * $urandom_range(1, 4);
        // Break some loads off early to leave the counter mid-entry.
        if ($urandom_range(99) < 15) n_bytes = $urandom_range(0, n_bytes - 1);
        send_request(rand_request(MODE_WRITE, OFS_ADDRESS), 1'b0, '0);
        repeat (n_bytes) send_request(rand_request(MODE_WRITE, OFS_COLOR), 1'b0, '0);
      end else if (pick < 80) begin
        send_request(rand_request(MODE_WRITE, OFS_COLOR), 1'b0, '0);
      end else begin
        send_request(rand_request(MODE_WRITE, 3'($urandom_range(7))), 1'b0, '0);
      end
    end
  endtask

  // Hold the sender until every outstanding response has come back.
  task automatic drain;
    req_valid = 1'b0;
    while (expected_colors.size() != 0) @(negedge clk);
  endtask

  // Receiver: stall at random, or hold off entirely while hold_cycles runs down.
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready = 1'b0;
    end else if (hold_cycles > 0) begin
      rsp_ready = 1'b0;
      hold_cycles--;
    end else begin
      rsp_ready = (rcv_idle_pct == 0) || ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Predict at request acceptance, check at response acceptance.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (req_valid && req_ready) begin
        want = apply_request(req);
        if (pin_valid) want = pin_rsp;
        expected_colors.push_back(want);
        if (req.mode == MODE_PIXEL) n_lookups++;
        else if (req.reg_offset == OFS_COLOR) n_color_bytes++;
        else if (want.unhandled_write) n_unhandled++;
      end
      if (rsp_valid && rsp_ready) begin
        n_responses++;
        if (expected_colors.size() == 0) begin
          $display("%0t: response with none expected: actual %h", $time, rsp);
          errors++;
        end else begin
          want = expected_colors.pop_front();
          if (rsp.first_color !== want.first_color) begin
            $display("%0t: first_color expected %h actual %h", $time,
                     want.first_color, rsp.first_color);
            errors++;
          end
          if (rsp.second_color !== want.second_color) begin
            $display("%0t: second_color expected %h actual %h", $time,
                     want.second_color, rsp.second_color);
            errors++;
          end
          if (rsp.unhandled_write !== want.unhandled_write) begin
            $display("%0t: unhandled_write expected %h actual %h", $time,
                     want.unhandled_write, rsp.unhandled_write);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d responses outstanding", $time,
               expected_colors.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    foreach (shadow_palette[i]) shadow_palette[i] = '0;
    shadow_addr = '0;
    shadow_count = CC_RED;
    shadow_red = '0;
    shadow_green = '0;
    shadow_mask = '0;
    shadow_command = '0;

    // Directed plan. Lookups after loads go through the shadow; the rest
    // carry their response inline.
    // After reset every entry reads zero, whatever the ignored fields hold.
    directed_plan.push_back(plan_step(MODE_PIXEL, OFS_ADDRESS, 8'h00, 16'h0000, 1, 0, 0, 0));
    directed_plan.push_back(plan_step(MODE_PIXEL, OFS_SPARE7, 8'hff, 16'hffff, 1, 0, 0, 0));
    // Undecoded offsets: flag set, no state change.
    directed_plan.push_back(plan_step(MODE_WRITE, OFS_SPARE3, 8'haa, 16'hffff, 1, 0, 0, 1));
    directed_plan.push_back(plan_step(MODE_WRITE, OFS_SPARE4, 8'h55, 16'h0000, 1, 0, 0, 1));
    directed_plan.push_back(plan_step(MODE_WRITE, OFS_SPARE5, 8'hff, 16'h5a5a, 1, 0, 0, 1));
    directed_plan.push_back(plan_step(MODE_WRITE, OFS_SPARE7, 8'h00, 16'ha5a5, 1, 0, 0, 1));
    // Load the last entry, then let the address wrap onto entry zero.
    directed_plan.push_back(plan_step(MODE_WRITE, OFS_ADDRESS, 8'hff, 16'hffff, 1, 0, 0, 0));
    directed_plan.push_back(plan_step(MODE_WRITE, OFS_COLOR, 8'hff, 16'h0000, 1, 0, 0, 0));
    directed_plan.push_back(plan_step(MODE_WRITE, OFS_COLOR, 8'h00, 16'hffff, 1, 0, 0, 0));
    directed_plan.push_back(plan_step(MODE_WRITE, OFS_COLOR, 8'h81, 16'h0000, 1, 0, 0, 0));
    directed_plan.push_back(plan_step(MODE_WRITE, OFS_COLOR, 8'h12, 16'h0000, 1, 0, 0, 0));
    directed_plan.push_back(plan_step(MODE_WRITE, OFS_COLOR, 8'h34, 16'h0000, 1, 0, 0, 0));
    directed_plan.push_back(plan_step(MODE_WRITE, OFS_COLOR, 8'h56, 16'h0000, 1, 0, 0, 0));
    directed_plan.push_back(plan_step(MODE_PIXEL, OFS_ADDRESS, 8'h00, 16'h00ff, 0, 0, 0, 0));
    directed_plan.push_back(plan_step(MODE_PIXEL, OFS_COLOR, 8'hff, 16'hff00, 0, 0, 0, 0));
    // Mask and command are stored but must not touch the lookup.
    directed_plan.push_back(plan_step(MODE_WRITE, OFS_PIXMASK, 8'h00, 16'h0000, 1, 0, 0, 0));
    directed_plan.push_back(plan_step(MODE_WRITE, OFS_COMMAND, 8'hff, 16'h0000, 1, 0, 0, 0));
    directed_plan.push_back(plan_step(MODE_PIXEL, OFS_PIXMASK, 8'h00, 16'hff00, 0, 0, 0, 0));
    directed_plan.push_back(plan_step(MODE_WRITE, OFS_PIXMASK, 8'hff, 16'h0000, 1, 0, 0, 0));
    // An address write in mid-entry drops the staged red byte.
    directed_plan.push_back(plan_step(MODE_WRITE, OFS_ADDRESS, 8'h10, 16'h0000, 1, 0, 0, 0));
    directed_plan.push_back(plan_step(MODE_WRITE, OFS_COLOR, 8'hab, 16'h0000, 1, 0, 0, 0));
    directed_plan.push_back(plan_step(MODE_WRITE, OFS_ADDRESS, 8'h20, 16'h0000, 1, 0, 0, 0));
    directed_plan.push_back(plan_step(MODE_WRITE, OFS_COLOR, 8'hff, 16'h0000, 1, 0, 0, 0));
    directed_plan.push_back(plan_step(MODE_WRITE, OFS_COLOR, 8'hff, 16'h0000, 1, 0, 0, 0));
    directed_plan.push_back(plan_step(MODE_WRITE, OFS_COLOR, 8'hff, 16'h0000, 1, 0, 0, 0));
    directed_plan.push_back(plan_step(MODE_PIXEL, OFS_ADDRESS, 8'h00, 16'h2010, 0, 0, 0, 0));

    // Hold reset, release at a falling edge.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, both sides free running.
    foreach (directed_plan[i])
      send_request(directed_plan[i].rq, directed_plan[i].pinned, directed_plan[i].rs);
    drain();

    // Sender gaps light, receiver stalls heavy.
    send_idle_pct = 30;
    rcv_idle_pct = 66;
    drive_random_traffic(500);
    drain();

    // And the other way round.
    send_idle_pct = 66;
    rcv_idle_pct = 30;
    drive_random_traffic(500);
    drain();

    // No idling. Start with a long receiver hold-off so the queue fills and
    // back-pressures the request side.
    send_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_cycles = HOLD_OFF_CYCLES;
    drive_random_traffic(525);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    errors += expected_colors.size();
    $display("Covered %0d requests: %0d lookups, %0d color bytes, %0d undecoded writes",
             issued, n_lookups, n_color_bytes, n_unhandled);
    $display("Checked %0d responses, %0d errors, %0d cycles", n_responses, errors, cycles);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
